/* hdl/acd_pkg.sv */
// Shared constants and types for the amount compress/decompress unit.
// Used by acd_alu and by the top level; depends on nothing else.
package acd_pkg;

    localparam int unsigned VAL_W      = 64;   // Amount and code width.
    localparam int unsigned ACC_W      = 96;   // Exact result fits below 2^94.
    localparam int unsigned CHUNK_W    = 16;   // Dividend bits consumed per division step.
    localparam int unsigned NUM_CHUNKS = VAL_W / CHUNK_W;
    localparam int unsigned CIDX_W     = $clog2(NUM_CHUNKS);
    localparam int unsigned REM_W      = 4;    // Holds a remainder or digit 0..9.
    localparam int unsigned DIG_W      = REM_W + CHUNK_W;
    localparam int unsigned PROD_W     = 2 * DIG_W;

    // Reciprocals for exact division of a DIG_W-bit value, scaled by 2^RECIP_SHIFT.
    localparam int unsigned RECIP_SHIFT = 23;
    localparam logic [DIG_W-1:0] RECIP_10 = DIG_W'(838861);
    localparam logic [DIG_W-1:0] RECIP_9  = DIG_W'(932068);

    // Largest decimal exponent of the code.
    localparam logic [REM_W-1:0] EXP_MAX = REM_W'(9);

    // Operation select carried with each input transaction.
    typedef enum logic {
        OP_COMPRESS   = 1'b0,
        OP_DECOMPRESS = 1'b1
    } op_t;

    // Multiplier applied to the accumulator by the multiply-add path.
    typedef enum logic [1:0] {
        MUL_1  = 2'd0,
        MUL_9  = 2'd1,
        MUL_10 = 2'd2
    } mul_t;

    typedef struct packed {
        logic               div_by9;  // Divide by nine instead of ten.
        logic [REM_W-1:0]   rem;      // Running remainder entering this step.
        logic [CHUNK_W-1:0] chunk;    // Next dividend chunk, most significant first.
        mul_t               mul;      // Multiply-add scale.
        logic [REM_W-1:0]   addend;   // Small constant added after scaling.
    } alu_req_t;

    typedef struct packed {
        logic [CHUNK_W-1:0] quo;      // Quotient chunk of this step.
        logic [REM_W-1:0]   rem;      // Remainder leaving this step.
        logic [ACC_W-1:0]   acc;      // Scaled accumulator plus addend.
    } alu_rsp_t;

endpackage

/* hdl/acd_alu.sv */
// Shared arithmetic unit: one long-division step by 9 or 10 on a 16-bit chunk,
// and a multiply-add by 1, 9 or 10 on the 96-bit accumulator. Uses acd_pkg.
module acd_alu (
    input  acd_pkg::alu_req_t           req,
    input  logic [acd_pkg::ACC_W-1:0]   acc,
    output acd_pkg::alu_rsp_t           rsp
);
    import acd_pkg::*;

    logic [DIG_W-1:0]   dig;
    logic [DIG_W-1:0]   recip;
    logic [PROD_W-1:0]  prod;
    logic [CHUNK_W-1:0] quo;
    logic [DIG_W-1:0]   quo_times_d;
    logic [DIG_W-1:0]   rem_full;
    logic [ACC_W-1:0]   scaled;

    // The remainder is below the divisor, so the quotient chunk fits in CHUNK_W bits.
    assign dig   = {req.rem, req.chunk};
    assign recip = req.div_by9 ? RECIP_9 : RECIP_10;
    assign prod  = PROD_W'(dig) * PROD_W'(recip);
    assign quo   = prod[RECIP_SHIFT +: CHUNK_W];

    assign quo_times_d = req.div_by9
        ? (DIG_W'({quo, 3'b000}) + DIG_W'(quo))
        : (DIG_W'({quo, 3'b000}) + DIG_W'({quo, 1'b0}));
    assign rem_full    = dig - quo_times_d;

    always_comb
    begin
        case (req.mul)
            MUL_9:   scaled = (acc << 3) + acc;
            MUL_10:  scaled = (acc << 3) + (acc << 1);
            default: scaled = acc;
        endcase
    end

    assign rsp.quo = quo;
    assign rsp.rem = rem_full[REM_W-1:0];
    assign rsp.acc = scaled + ACC_W'(req.addend);

endmodule

/* hdl/amount_compress_decompress_unit.sv */
// Top level of the amount compress/decompress unit: stream ports, sequencer
// and working registers. Uses acd_pkg and instantiates acd_alu.
//
//  Channel   Dir  Handshake               Payload
//  s_axis    in   tvalid/tready           tdata = value, tuser = operation
//  m_axis    out  tvalid/tready           tdata = result, tuser = overflow
//
// One transaction is worked on at a time; s_axis_tready is high only while the
// sequencer is idle. Each division by nine or ten runs through the shared unit,
// one 16-bit chunk a cycle, and each multiply by ten is a single pass through it.
// A zero value skips the division and goes straight to the done state. The result
// sits in an output register, so a stalled m_axis only holds the finished item in
// the done state; rst_n clears the sequencer and the output valid flag at once.
module amount_compress_decompress_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [acd_pkg::VAL_W-1:0]  s_axis_tdata,   // [63:0] value
    input  logic                       s_axis_tuser,   // [0] operation
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [acd_pkg::VAL_W-1:0]  m_axis_tdata,   // [63:0] result
    output logic                       m_axis_tuser    // [0] overflow
);
    import acd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MAC_A,
        S_MAC_B,
        S_SCALE,
        S_DONE
    } state_t;

    // What the running division is for.
    typedef enum logic [1:0] {
        PH_STRIP,   // Compress: trial division to strip a trailing zero.
        PH_DIV10,   // Decompress: split off the exponent.
        PH_DIV9     // Decompress: split off the last digit.
    } phase_t;

    state_t             state_reg,     state_next;
    phase_t             phase_reg,     phase_next;
    logic [VAL_W-1:0]   num_reg,       num_next;
    logic [VAL_W-1:0]   quo_reg,       quo_next;
    logic [REM_W-1:0]   rem_reg,       rem_next;
    logic [CIDX_W-1:0]  cidx_reg,      cidx_next;
    logic [REM_W-1:0]   exp_reg,       exp_next;
    logic [REM_W-1:0]   scale_reg,     scale_next;
    logic [ACC_W-1:0]   acc_reg,       acc_next;
    mul_t               mul_a_reg,     mul_a_next;
    logic [REM_W-1:0]   add_a_reg,     add_a_next;
    logic [REM_W-1:0]   add_b_reg,     add_b_next;
    logic               need_b_reg,    need_b_next;
    logic [VAL_W-1:0]   res_reg,       res_next;
    logic               ovf_reg,       ovf_next;
    logic               out_valid_reg, out_valid_next;

    logic [NUM_CHUNKS-1:0][CHUNK_W-1:0] num_chunks;
    logic [VAL_W-1:0]                   quo_full;
    alu_req_t                           alu_req;
    alu_rsp_t                           alu_rsp;

    acd_alu u_alu (
        .req (alu_req),
        .acc (acc_reg),
        .rsp (alu_rsp)
    );

    // The dividend is consumed most significant chunk first; the quotient
    // shifts in from the bottom, so it is complete after the last chunk.
    assign num_chunks = num_reg;
    assign quo_full   = {quo_reg[VAL_W-CHUNK_W-1:0], alu_rsp.quo};

    always_comb
    begin
        alu_req.div_by9 = (phase_reg == PH_DIV9);
        alu_req.rem     = rem_reg;
        alu_req.chunk   = num_chunks[cidx_reg];
        alu_req.mul     = (state_reg == S_MAC_A) ? mul_a_reg : MUL_10;
        case (state_reg)
            S_MAC_A: alu_req.addend = add_a_reg;
            S_MAC_B: alu_req.addend = add_b_reg;
            default: alu_req.addend = '0;
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = res_reg;
    assign m_axis_tuser  = ovf_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        cidx_next      = cidx_reg;
        exp_next       = exp_reg;
        scale_next     = scale_reg;
        acc_next       = acc_reg;
        mul_a_next     = mul_a_reg;
        add_a_next     = add_a_reg;
        add_b_next     = add_b_reg;
        need_b_next    = need_b_reg;
        res_next       = res_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    exp_next   = '0;
                    scale_next = '0;
                    rem_next   = '0;
                    cidx_next  = CIDX_W'(NUM_CHUNKS - 1);
                    acc_next   = '0;
                    if (s_axis_tdata == '0)
                    begin
                        // Zero maps to zero in both directions.
                        state_next = S_DONE;
                    end
                    else if (op_t'(s_axis_tuser) == OP_COMPRESS)
                    begin
                        num_next   = s_axis_tdata;
                        phase_next = PH_STRIP;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        num_next   = s_axis_tdata - VAL_W'(1);
                        phase_next = PH_DIV10;
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                rem_next  = alu_rsp.rem;
                quo_next  = quo_full;
                cidx_next = cidx_reg - CIDX_W'(1);
                if (cidx_reg == '0)
                begin
                    // Division complete; set up the next one or the combine.
                    rem_next  = '0;
                    cidx_next = CIDX_W'(NUM_CHUNKS - 1);
                    case (phase_reg)
                        PH_STRIP:
                        begin
                            if (alu_rsp.rem == '0)
                            begin
                                num_next = quo_full;
                                exp_next = exp_reg + REM_W'(1);
                                if (exp_reg == EXP_MAX - REM_W'(1))
                                begin
                                    // Nine zeros stripped: the code is ten times the rest.
                                    acc_next    = ACC_W'(quo_full);
                                    mul_a_next  = MUL_10;
                                    add_a_next  = '0;
                                    need_b_next = 1'b0;
                                    state_next  = S_MAC_A;
                                end
                            end
                            else
                            begin
                                // Code is 10*(9n + d - 1) + 1 + e.
                                acc_next    = ACC_W'(quo_full);
                                mul_a_next  = MUL_9;
                                add_a_next  = alu_rsp.rem - REM_W'(1);
                                add_b_next  = exp_reg + REM_W'(1);
                                need_b_next = 1'b1;
                                state_next  = S_MAC_A;
                            end
                        end

                        PH_DIV10:
                        begin
                            scale_next = alu_rsp.rem;
                            if (alu_rsp.rem == EXP_MAX)
                            begin
                                acc_next    = ACC_W'(quo_full);
                                mul_a_next  = MUL_1;
                                add_a_next  = REM_W'(1);
                                need_b_next = 1'b0;
                                state_next  = S_MAC_A;
                            end
                            else
                            begin
                                num_next   = quo_full;
                                phase_next = PH_DIV9;
                            end
                        end

                        default:
                        begin
                            // Mantissa is ten times the quotient plus the digit.
                            acc_next    = ACC_W'(quo_full);
                            mul_a_next  = MUL_10;
                            add_a_next  = alu_rsp.rem + REM_W'(1);
                            need_b_next = 1'b0;
                            state_next  = S_MAC_A;
                        end
                    endcase
                end
            end

            S_MAC_A:
            begin
                acc_next   = alu_rsp.acc;
                state_next = need_b_reg ? S_MAC_B : S_SCALE;
            end

            S_MAC_B:
            begin
                acc_next   = alu_rsp.acc;
                state_next = S_SCALE;
            end

            S_SCALE:
            begin
                if (scale_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    acc_next   = alu_rsp.acc;
                    scale_next = scale_reg - REM_W'(1);
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    res_next       = acc_reg[VAL_W-1:0];
                    ovf_next       = |acc_reg[ACC_W-1:VAL_W];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_STRIP;
            num_reg       <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            cidx_reg      <= '0;
            exp_reg       <= '0;
            scale_reg     <= '0;
            acc_reg       <= '0;
            mul_a_reg     <= MUL_1;
            add_a_reg     <= '0;
            add_b_reg     <= '0;
            need_b_reg    <= 1'b0;
            res_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            num_reg       <= num_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            cidx_reg      <= cidx_next;
            exp_reg       <= exp_next;
            scale_reg     <= scale_next;
            acc_reg       <= acc_next;
            mul_a_reg     <= mul_a_next;
            add_a_reg     <= add_a_next;
            add_b_reg     <= add_b_next;
            need_b_reg    <= need_b_next;
            res_reg       <= res_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
